// ----- src/zero_run_row_decoder_assert.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef ZERO_RUN_ROW_DECODER_ASSERT_SVH
`define ZERO_RUN_ROW_DECODER_ASSERT_SVH

// same-cycle implication
`define ZRD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zrd check failed");

// next-cycle implication
`define ZRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zrd check failed");

`endif

// ----- src/zrd_pkg.sv -----
`default_nettype none

package zrd_pkg;

    localparam int DIM_BITS   = 12;
    localparam int LEN_BITS   = 16;
    localparam int CNT_BITS   = 24;
    localparam int HDR_BYTES  = 2;

    localparam logic [LEN_BITS-1:0] COLUMN_MAX = '1;
    localparam logic [CNT_BITS-1:0] COUNT_MAX  = '1;

    typedef enum logic [1:0] {
        PH_LEN_LO = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_BODY   = 2'd2,
        PH_RUN    = 2'd3
    } phase_t;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]          pixel_value;
        logic [DIM_BITS-1:0] repeat_res;
        logic                frame_done;
        logic [CNT_BITS-1:0] total_written;
    } result_t;

endpackage

`default_nettype wire

// ----- src/zrd_byte_if.sv -----
`default_nettype none

interface zrd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- src/zrd_pixel_if.sv -----
`default_nettype none

interface zrd_pixel_if
    import zrd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [7:0]          pixel_value;
    logic [DIM_BITS-1:0] repeat_res;
    logic                frame_done;
    logic [CNT_BITS-1:0] total_written;

    modport source (output valid, output pixel_value, output repeat_res,
                    output frame_done, output total_written, input ready);
    modport sink   (input valid, input pixel_value, input repeat_res,
                    input frame_done, input total_written, output ready);
endinterface

`default_nettype wire

// ----- src/zero_run_row_decoder.sv -----
// A byte passes through the input register and then the result register; its word (if any)
//   waits longer only while a stalled result register holds the previous word.
// Throughput: one input byte per cycle while the output is not stalled; the input register and the
//   result register decouple the two channels, so a stalled output holds one word.
// Reset (rst_n low, asynchronous): pipeline empty, phase waits for a row length
//   low byte, counters zero, frame_width and frame_height both 1.
`default_nettype none

`include "zero_run_row_decoder_assert.svh"

module zero_run_row_decoder
    import zrd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [DIM_BITS-1:0] cfg_data,
    zrd_byte_if.sink                 stream,
    zrd_pixel_if.source              pixels
);

    // configuration
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_BITS'(1);
            height_reg <= DIM_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    logic       s1_adv;

    assign s1_adv       = !out_valid_reg || pixels.ready;
    assign stream.ready = !in_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (stream.ready)
            in_valid_reg <= stream.valid;
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
            byte_reg <= stream.data_byte;
    end

    // decoder state
    phase_t              phase_reg,         phase_next;
    logic [7:0]          length_low_reg,    length_low_next;
    logic [LEN_BITS-1:0] bytes_left_reg,    bytes_left_next;
    logic [LEN_BITS-1:0] column_reg,        column_next;
    logic [DIM_BITS-1:0] row_index_reg,     row_index_next;
    logic [CNT_BITS-1:0] written_count_reg, written_count_next;

    logic                s1_fire;
    logic                emit;
    logic                row_end;
    logic                done;
    logic [7:0]          pv;
    logic [DIM_BITS-1:0] rep;
    logic [LEN_BITS-1:0] row_len;
    logic [LEN_BITS-1:0] bl_dec;
    logic [LEN_BITS:0]   run_end;
    logic [DIM_BITS:0]   row_inc;
    logic [CNT_BITS:0]   count_sum;
    logic [CNT_BITS-1:0] count_sat;
    result_t             result_next;

    assign s1_fire = in_valid_reg && s1_adv;
    assign row_len = {byte_reg, length_low_reg};
    assign bl_dec  = (bytes_left_reg != '0) ? bytes_left_reg - LEN_BITS'(1) : '0;
    assign run_end = {1'b0, column_reg} + (LEN_BITS + 1)'(byte_reg);
    assign row_inc = {1'b0, row_index_reg} + (DIM_BITS + 1)'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        length_low_next = length_low_reg;
        bytes_left_next = bytes_left_reg;
        column_next     = column_reg;
        row_index_next  = row_index_reg;
        emit            = 1'b0;
        row_end         = 1'b0;
        done            = 1'b0;
        pv              = '0;
        rep             = '0;

        unique case (phase_reg)
            PH_LEN_LO:
            begin
                length_low_next = byte_reg;
                phase_next      = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                column_next = '0;
                if (row_len < LEN_BITS'(HDR_BYTES + 1))
                    row_end = 1'b1;
                else
                begin
                    bytes_left_next = row_len - LEN_BITS'(HDR_BYTES);
                    phase_next      = PH_BODY;
                end
            end
            PH_BODY:
            begin
                bytes_left_next = bl_dec;
                if (byte_reg != '0)
                begin
                    emit = 1'b1;
                    pv   = byte_reg;
                    rep  = DIM_BITS'(1);
                    if (column_reg != COLUMN_MAX)
                        column_next = column_reg + LEN_BITS'(1);
                end
                else if (bl_dec != '0)
                    phase_next = PH_RUN;
                if (bl_dec == '0)
                    row_end = 1'b1;
            end
            PH_RUN:
            begin
                bytes_left_next = bl_dec;
                emit            = 1'b1;
                phase_next      = PH_BODY;
                // clip the run to the columns left in the row
                if (column_reg >= LEN_BITS'(width_reg))
                    rep = '0;
                else if (run_end > (LEN_BITS + 1)'(width_reg))
                    rep = width_reg - column_reg[DIM_BITS-1:0];
                else
                    rep = DIM_BITS'(byte_reg);
                column_next = column_reg + LEN_BITS'(rep);
                if (bl_dec == '0)
                    row_end = 1'b1;
            end
            default: ;
        endcase

        if (row_end)
        begin
            phase_next = PH_LEN_LO;
            if (row_inc >= {1'b0, height_reg})
            begin
                done           = 1'b1;
                row_index_next = '0;
            end
            else
                row_index_next = row_inc[DIM_BITS-1:0];
        end
    end

    assign count_sum = {1'b0, written_count_reg} + (CNT_BITS + 1)'(rep);
    assign count_sat = count_sum[CNT_BITS] ? COUNT_MAX : count_sum[CNT_BITS-1:0];

    always_comb
    begin
        written_count_next = written_count_reg;
        if (emit || done)
            written_count_next = done ? '0 : count_sat;
        result_next.pixel_value   = pv;
        result_next.repeat_res    = rep;
        result_next.frame_done    = done;
        result_next.total_written = count_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_LEN_LO;
            length_low_reg    <= '0;
            bytes_left_reg    <= '0;
            column_reg        <= '0;
            row_index_reg     <= '0;
            written_count_reg <= '0;
        end
        else if (s1_fire)
        begin
            phase_reg         <= phase_next;
            length_low_reg    <= length_low_next;
            bytes_left_reg    <= bytes_left_next;
            column_reg        <= column_next;
            row_index_reg     <= row_index_next;
            written_count_reg <= written_count_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= s1_fire && (emit || done);
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && (emit || done))
            result_reg <= result_next;
    end

    assign pixels.valid         = out_valid_reg;
    assign pixels.pixel_value   = result_reg.pixel_value;
    assign pixels.repeat_res    = result_reg.repeat_res;
    assign pixels.frame_done    = result_reg.frame_done;
    assign pixels.total_written = result_reg.total_written;

    `ZRD_ASSERT_NEXT(a_done_clears_count, s1_fire && done, written_count_reg == '0)
    `ZRD_ASSERT_NOW(a_run_has_bytes, phase_reg == PH_RUN, bytes_left_reg != '0)
    `ZRD_ASSERT_NOW(a_literal_single,
        out_valid_reg && result_reg.pixel_value != '0,
        result_reg.repeat_res == DIM_BITS'(1))
    `ZRD_ASSERT_NEXT(a_stalled_input_holds, in_valid_reg && !s1_adv,
        in_valid_reg && $stable(byte_reg))

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import zrd_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int MAX_PRINTS = 30;

    class pixel_scoreboard;
        phase_t              ph = PH_LEN_LO;
        logic [7:0]          len_lo = '0;
        logic [LEN_BITS-1:0] bytes_left = '0;
        logic [LEN_BITS-1:0] column = '0;
        logic [DIM_BITS-1:0] row_index = '0;
        logic [CNT_BITS-1:0] written = '0;
        logic [DIM_BITS-1:0] width_reg = DIM_BITS'(1);
        logic [DIM_BITS-1:0] height_reg = DIM_BITS'(1);
        result_t             expected_pixels[$];
        int                  errors = 0;

        function void set_reg(cfg_index_t idx, logic [DIM_BITS-1:0] v);
            if (idx == REG_FRAME_WIDTH)
                width_reg = v;
            else
                height_reg = v;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        // advance the decoder state by one accepted byte
        function void push_byte(logic [7:0] b);
            bit          emit;
            bit          row_end;
            bit          done;
            logic [7:0]  pv;
            int unsigned rep;
            int unsigned len;
            int unsigned sum;
            result_t     r;
            emit = 0;
            row_end = 0;
            done = 0;
            pv = '0;
            rep = 0;
            case (ph)
                PH_LEN_LO:
                begin
                    len_lo = b;
                    ph = PH_LEN_HI;
                    return;
                end
                PH_LEN_HI:
                begin
                    len = {16'd0, b, len_lo};
                    column = '0;
                    if (len < HDR_BYTES + 1)
                        row_end = 1;
                    else
                    begin
                        bytes_left = LEN_BITS'(len - HDR_BYTES);
                        ph = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (bytes_left != 0)
                        bytes_left--;
                    if (b != 0)
                    begin
                        emit = 1;
                        pv = b;
                        rep = 1;
                        if (column < COLUMN_MAX)
                            column++;
                    end
                    else if (bytes_left != 0)
                        ph = PH_RUN;
                    if (bytes_left == 0)
                        row_end = 1;
                end
                default:
                begin
                    rep = {24'd0, b};
                    if (bytes_left != 0)
                        bytes_left--;
                    if (column >= width_reg)
                        rep = 0;
                    else if (column + rep > width_reg)
                        rep = width_reg - column;
                    sum = column + rep;
                    column = (sum > COLUMN_MAX) ? COLUMN_MAX : sum[LEN_BITS-1:0];
                    emit = 1;
                    ph = PH_BODY;
                    if (bytes_left == 0)
                        row_end = 1;
                end
            endcase

            if (row_end)
            begin
                ph = PH_LEN_LO;
                if (int'(row_index) + 1 >= int'(height_reg))
                begin
                    done = 1;
                    row_index = '0;
                end
                else
                    row_index = row_index + 1'b1;
            end

            if (!emit && !done)
                return;

            sum = written + rep;
            if (sum > COUNT_MAX)
                sum = COUNT_MAX;
            r.pixel_value = pv;
            r.repeat_res = rep[DIM_BITS-1:0];
            r.frame_done = done;
            r.total_written = sum[CNT_BITS-1:0];
            expected_pixels.push_back(r);
            written = done ? '0 : sum[CNT_BITS-1:0];
        endfunction

        task check_pixel(result_t got);
            result_t want;
            if (expected_pixels.size() == 0)
            begin
                report($sformatf("word with nothing pending: value %0h repeat %0d",
                                 got.pixel_value, got.repeat_res));
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_value !== want.pixel_value)
                report($sformatf("pixel_value got %0h want %0h",
                                 got.pixel_value, want.pixel_value));
            if (got.repeat_res !== want.repeat_res)
                report($sformatf("repeat_res got %0d want %0d",
                                 got.repeat_res, want.repeat_res));
            if (got.frame_done !== want.frame_done)
                report($sformatf("frame_done got %0b want %0b",
                                 got.frame_done, want.frame_done));
            if (got.total_written !== want.total_written)
                report($sformatf("total_written got %0d want %0d",
                                 got.total_written, want.total_written));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [DIM_BITS-1:0] cfg_data;

    zrd_byte_if  stream ();
    zrd_pixel_if pixels ();

    zero_run_row_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stream    (stream),
        .pixels    (pixels)
    );

    pixel_scoreboard sb = new();

    logic [7:0] row_bytes[$];
    int         burst_left;
    int         sent_bytes;
    int         cycle_count;
    bit         hold_go;
    bit         hold;

    int unsigned phase_width[8]  = '{5, 1, 4095, 17, 12, 4095, 40, 3};
    int unsigned phase_height[8] = '{2, 1, 3, 4095, 0, 4095, 7, 1};

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_byte(logic [7:0] b);
        int gap;
        stream.valid <= 1'b1;
        stream.data_byte <= b;
        @(posedge clk);
        while (!stream.ready)
            @(posedge clk);
        sb.push_byte(b);
        sent_bytes++;
        burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                stream.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_row();
        for (int i = 0; i < row_bytes.size(); i++)
            send_byte(row_bytes[i]);
    endtask

    // wait until every pending word is out and the pipeline has drained
    task automatic settle();
        stream.valid <= 1'b0;
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_dims(int unsigned w, int unsigned h);
        cfg_we <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data <= w[DIM_BITS-1:0];
        @(posedge clk);
        sb.set_reg(REG_FRAME_WIDTH, w[DIM_BITS-1:0]);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data <= h[DIM_BITS-1:0];
        @(posedge clk);
        sb.set_reg(REG_FRAME_HEIGHT, h[DIM_BITS-1:0]);
        cfg_we <= 1'b0;
    endtask

    function automatic void build_row(int unsigned w);
        logic [7:0]  body[$];
        int unsigned kind;
        int unsigned n;
        int unsigned len;
        int unsigned cap;
        row_bytes.delete();
        kind = $urandom_range(0, 99);
        cap = (w + 2 > 255) ? 255 : w + 2;
        if (kind < 5)
        begin
            // short length, empty row
            row_bytes.push_back(8'($urandom_range(0, 2)));
            row_bytes.push_back(8'h00);
            return;
        end
        if (kind < 10)
        begin
            n = $urandom_range(1, 20);
            repeat (n) body.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            n = (kind < 13) ? $urandom_range(130, 200) : $urandom_range(0, 10);
            repeat (n)
            begin
                if ($urandom_range(0, 9) < 6)
                    body.push_back(8'($urandom_range(1, 255)));
                else
                begin
                    body.push_back(8'h00);
                    body.push_back(8'($urandom_range(0, 1) ? $urandom_range(0, cap)
                                                            : $urandom_range(0, 255)));
                end
            end
            if (kind >= 13 && kind < 21)
                body.push_back(8'h00);
        end
        len = body.size() + 2;
        row_bytes.push_back(len[7:0]);
        row_bytes.push_back(len[15:8]);
        foreach (body[i])
            row_bytes.push_back(body[i]);
    endfunction

    // receiver: check accepted words, stall on shifting patterns
    initial
    begin
        result_t seen;
        int      mode;
        int      span;
        span = 0;
        mode = 0;
        pixels.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pixels.valid && pixels.ready)
            begin
                seen.pixel_value = pixels.pixel_value;
                seen.repeat_res = pixels.repeat_res;
                seen.frame_done = pixels.frame_done;
                seen.total_written = pixels.total_written;
                sb.check_pixel(seen);
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 80);
            end
            span--;
            if (hold)
                pixels.ready <= 1'b0;
            else
                case (mode)
                    0: pixels.ready <= 1'b1;
                    1: pixels.ready <= ($urandom_range(0, 3) != 0);
                    2: pixels.ready <= ($urandom_range(0, 9) < 3);
                    default: pixels.ready <= ~pixels.ready;
                endcase
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold <= 1'b1;
        repeat (600) @(posedge clk);
        hold <= 1'b0;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int start;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data <= '0;
        stream.valid <= 1'b0;
        stream.data_byte <= '0;
        burst_left = $urandom_range(1, 32);
        sent_bytes = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // literals, runs (zero, clipped), empty and broken rows, frame ends
        set_dims(6, 3);
        row_bytes = '{8'h0B, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h03, 8'h00, 8'h00,
                      8'h00, 8'hFF, 8'h80,
                      8'h02, 8'h00,
                      8'h04, 8'h00, 8'h7F, 8'h00,
                      8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00};
        send_row();

        for (int p = 0; p < 8; p++)
        begin
            settle();
            set_dims(phase_width[p], phase_height[p]);
            if (p == 1)
                hold_go = 1'b1;
            start = sent_bytes;
            while (sent_bytes - start < 100)
            begin
                build_row(sb.width_reg);
                send_row();
            end
        end

        settle();
        if (sb.errors == 0 && sb.expected_pixels.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
